// File: hdl/dhs_pkg.sv
// types and constants shared by the disk head scheduler
`default_nettype none
package dhs_pkg;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SCAN  = 2'd1,
    POL_LOOK  = 2'd2,
    POL_CSCAN = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    REG_POLICY = 2'd0,
    REG_START  = 2'd1,
    REG_PREV   = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IRD,
    S_ICMP,
    S_IZERO,
    S_SRD,
    S_SCMP,
    S_STEP,
    S_FETCH,
    S_END2
  } state_e;

  localparam int CylW = 16;
  localparam int SumW = 21;
  localparam logic [CylW-1:0] TopReset = 16'd4999;

  typedef struct packed {
    logic [CylW-1:0] cylinder;
    logic            batch_end;
  } in_item_t;

  typedef struct packed {
    logic [CylW-1:0] destination;
    logic            end_visit;
    logic [SumW-1:0] movement_total;
    logic            last_move;
  } out_item_t;

  typedef struct packed {
    policy_e         policy;
    logic [CylW-1:0] start_position;
    logic [CylW-1:0] previous_position;
    logic [CylW-1:0] top_cylinder;
  } cfg_t;

endpackage
`default_nettype wire

// File: hdl/dhs_mem.sv
// single-port-write, registered-read memory for request storage
`default_nettype none
module dhs_mem #(
  parameter int Width = 16,
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: hdl/dhs_cfg.sv
// apb configuration registers
`default_nettype none
module dhs_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output dhs_pkg::cfg_t    cfg_o
);
  import dhs_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.policy            <= POL_FCFS;
      cfg_q.start_position    <= '0;
      cfg_q.previous_position <= '0;
      cfg_q.top_cylinder      <= TopReset;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_POLICY: cfg_q.policy            <= policy_e'(pwdata[1:0]);
        REG_START:  cfg_q.start_position    <= pwdata[CylW-1:0];
        REG_PREV:   cfg_q.previous_position <= pwdata[CylW-1:0];
        REG_TOP:    cfg_q.top_cylinder      <= pwdata[CylW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_POLICY: prdata = {30'd0, cfg_q.policy};
      REG_START:  prdata = {16'd0, cfg_q.start_position};
      REG_PREV:   prdata = {16'd0, cfg_q.previous_position};
      REG_TOP:    prdata = {16'd0, cfg_q.top_cylinder};
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/dhs_ctrl.sv
// sequencer: loading with sorted insertion, start search and move generation
`default_nettype none
module dhs_ctrl #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dhs_pkg::cfg_t             cfg_i,
  input  wire logic                      in_valid_i,
  input  wire dhs_pkg::in_item_t         in_item_i,
  output logic                           in_stall_o,
  output logic                           out_valid_o,
  output dhs_pkg::out_item_t             out_item_o,
  input  wire logic                      out_stall_i,
  output logic                           req_we_o,
  output logic      [AddrW-1:0]          req_waddr_o,
  output logic      [dhs_pkg::CylW-1:0]  req_wdata_o,
  output logic      [AddrW-1:0]          req_raddr_o,
  input  wire logic [dhs_pkg::CylW-1:0]  req_rdata_i,
  output logic                           srt_we_o,
  output logic      [AddrW-1:0]          srt_waddr_o,
  output logic      [dhs_pkg::CylW-1:0]  srt_wdata_o,
  output logic      [AddrW-1:0]          srt_raddr_o,
  input  wire logic [dhs_pkg::CylW-1:0]  srt_rdata_i
);
  import dhs_pkg::*;

  localparam int CntW = $clog2(Depth + 1);
  localparam int NxtW = CntW + 1;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        pos_q, pos_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        up_q, up_d;
  logic [CntW-1:0]        done_q, done_d;
  logic signed [NxtW-1:0] next_q, next_d;
  logic                   upward_q, upward_d;
  logic                   batch_q, batch_d;
  logic [CylW-1:0]        cyl_q, cyl_d;
  logic [CylW-1:0]        head_q, head_d;
  logic [CylW-1:0]        end2_q, end2_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic                   slot, fin, init, emit, em_end, em_last;
  logic [CylW-1:0]        em_dest, clamp, span, fetch_data;
  logic [CntW-1:0]        init_up;
  logic signed [NxtW-1:0] n_s;

  assign slot  = !out_valid_q || !out_stall_i;
  assign clamp = (in_item_i.cylinder > cfg_i.top_cylinder) ? cfg_i.top_cylinder
                                                           : in_item_i.cylinder;
  assign n_s   = $signed({1'b0, count_q});
  assign fetch_data = (cfg_i.policy == POL_FCFS) ? req_rdata_i : srt_rdata_i;
  assign span  = (head_q > em_dest) ? head_q - em_dest : em_dest - head_q;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      upward_q    <= 1'b1;
      head_q      <= '0;
      sum_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      upward_q    <= upward_d;
      head_q      <= head_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    idx_q   <= idx_d;
    up_q    <= up_d;
    done_q  <= done_d;
    next_q  <= next_d;
    batch_q <= batch_d;
    cyl_q   <= cyl_d;
    end2_q  <= end2_d;
    out_q   <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    up_d        = up_q;
    done_d      = done_q;
    next_d      = next_q;
    upward_d    = upward_q;
    batch_d     = batch_q;
    cyl_d       = cyl_q;
    head_d      = head_q;
    end2_d      = end2_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    in_stall_o  = 1'b1;
    req_we_o    = 1'b0;
    req_waddr_o = count_q[AddrW-1:0];
    req_wdata_o = clamp;
    req_raddr_o = done_q[AddrW-1:0];
    srt_we_o    = 1'b0;
    srt_waddr_o = pos_q[AddrW-1:0];
    srt_wdata_o = cyl_q;
    srt_raddr_o = idx_q[AddrW-1:0];
    fin         = 1'b0;
    init        = 1'b0;
    init_up     = idx_q;
    emit        = 1'b0;
    em_dest     = '0;
    em_end      = 1'b0;
    em_last     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          batch_d = in_item_i.batch_end;
          cyl_d   = clamp;
          pos_d   = count_q;
          idx_d   = '0;
          if (count_q < CntW'(Depth)) begin
            req_we_o = 1'b1;
            if (count_q == '0) begin
              srt_we_o    = 1'b1;
              srt_waddr_o = '0;
              srt_wdata_o = clamp;
              count_d     = CntW'(1);
              state_d     = in_item_i.batch_end ? S_SRD : S_IDLE;
            end else begin
              state_d = S_IRD;
            end
          end else if (in_item_i.batch_end) begin
            state_d = S_SRD;
          end
        end
      end
      S_IRD: begin
        srt_raddr_o = AddrW'(pos_q - CntW'(1));
        state_d     = S_ICMP;
      end
      S_ICMP: begin
        srt_raddr_o = AddrW'(pos_q - CntW'(1));
        srt_we_o    = 1'b1;
        if (srt_rdata_i > cyl_q) begin
          srt_wdata_o = srt_rdata_i;
          pos_d       = pos_q - CntW'(1);
          state_d     = (pos_q == CntW'(1)) ? S_IZERO : S_IRD;
        end else begin
          fin = 1'b1;
        end
      end
      S_IZERO: begin
        srt_we_o = 1'b1;
        fin      = 1'b1;
      end
      S_SRD: begin
        if (idx_q == count_q) begin
          init = 1'b1;
        end else begin
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (cfg_i.start_position <= srt_rdata_i) begin
          init = 1'b1;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = S_SRD;
        end
      end
      S_STEP: begin
        srt_raddr_o = next_q[AddrW-1:0];
        if (cfg_i.policy == POL_FCFS) begin
          state_d = S_FETCH;
        end else if (upward_q) begin
          if (next_q < n_s) begin
            state_d = S_FETCH;
          end else if (slot) begin
            if (cfg_i.policy == POL_CSCAN) begin
              emit    = 1'b1;
              em_dest = cfg_i.top_cylinder;
              em_end  = 1'b1;
              end2_d  = '0;
              next_d  = '0;
              state_d = S_END2;
            end else begin
              emit     = (cfg_i.policy == POL_SCAN);
              em_dest  = cfg_i.top_cylinder;
              em_end   = 1'b1;
              upward_d = 1'b0;
              next_d   = $signed({1'b0, up_q}) - NxtW'(1);
            end
          end
        end else begin
          if (!next_q[NxtW-1]) begin
            state_d = S_FETCH;
          end else if (slot) begin
            if (cfg_i.policy == POL_CSCAN) begin
              emit    = 1'b1;
              em_dest = '0;
              em_end  = 1'b1;
              end2_d  = cfg_i.top_cylinder;
              next_d  = n_s - NxtW'(1);
              state_d = S_END2;
            end else begin
              emit     = (cfg_i.policy == POL_SCAN);
              em_dest  = '0;
              em_end   = 1'b1;
              upward_d = 1'b1;
              next_d   = $signed({1'b0, up_q});
            end
          end
        end
      end
      S_FETCH: begin
        srt_raddr_o = next_q[AddrW-1:0];
        if (slot) begin
          emit    = 1'b1;
          em_dest = fetch_data;
          em_last = (done_q + CntW'(1)) == count_q;
          done_d  = done_q + CntW'(1);
          next_d  = upward_q ? next_q + NxtW'(1) : next_q - NxtW'(1);
          if (em_last) begin
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            state_d = S_STEP;
          end
        end
      end
      S_END2: begin
        if (slot) begin
          emit    = 1'b1;
          em_dest = end2_q;
          em_end  = 1'b1;
          state_d = S_STEP;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      count_d = count_q + CntW'(1);
      idx_d   = '0;
      state_d = batch_q ? S_SRD : S_IDLE;
    end

    if (init) begin
      init_up  = idx_q;
      up_d     = init_up;
      upward_d = cfg_i.previous_position <= cfg_i.start_position;
      next_d   = upward_d ? $signed({1'b0, init_up})
                          : $signed({1'b0, init_up}) - NxtW'(1);
      done_d   = '0;
      head_d   = cfg_i.start_position;
      sum_d    = '0;
      state_d  = S_STEP;
    end

    if (emit) begin
      sum_d                = sum_q + SumW'(span);
      head_d               = em_dest;
      out_d.destination    = em_dest;
      out_d.end_visit      = em_end;
      out_d.movement_total = sum_d;
      out_d.last_move      = em_last;
      out_valid_d          = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: hdl/disk_head_scheduler.sv
// top level of the disk head scheduler
//
//   channel  dir  handshake            payload
//   in       in   in_valid_i/in_stall_o    in_item_i (cylinder, batch_end)
//   out      out  out_valid_o/out_stall_i  out_item_o (destination, end_visit,
//                                          movement_total, last_move)
//   cfg      in   apb psel/penable/pwrite  paddr, pwdata, prdata
//
// a request item goes straight into an empty store and a full store drops it;
// else it shifts each larger sorted entry up (S_IRD, S_ICMP) and is written in
// its place, via S_IZERO when it passes all of them; a batch end adds a start
// search (S_SRD, S_SCMP) before the first move; each request move reads memory
// (S_STEP, S_FETCH); a sweep end visit needs no read; a look turn emits nothing
// reset clears the control state; stored requests are not cleared
// out_stall_i holds the result register; a new batch loads while a result waits
`default_nettype none
module disk_head_scheduler #(
  parameter int RequestDepth = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire dhs_pkg::in_item_t  in_item_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  output dhs_pkg::out_item_t      out_item_o,
  input  wire logic               out_stall_i,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);
  import dhs_pkg::*;

  localparam int AddrW = (RequestDepth > 1) ? $clog2(RequestDepth) : 1;

  cfg_t            cfg;
  logic            req_we, srt_we;
  logic [AddrW-1:0] req_waddr, req_raddr, srt_waddr, srt_raddr;
  logic [CylW-1:0] req_wdata, req_rdata, srt_wdata, srt_rdata;

  dhs_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  dhs_mem #(.Width(CylW), .Depth(RequestDepth), .AddrW(AddrW)) u_req_mem (
    .clk_i, .we_i(req_we), .waddr_i(req_waddr), .wdata_i(req_wdata),
    .raddr_i(req_raddr), .rdata_o(req_rdata)
  );

  dhs_mem #(.Width(CylW), .Depth(RequestDepth), .AddrW(AddrW)) u_srt_mem (
    .clk_i, .we_i(srt_we), .waddr_i(srt_waddr), .wdata_i(srt_wdata),
    .raddr_i(srt_raddr), .rdata_o(srt_rdata)
  );

  dhs_ctrl #(.Depth(RequestDepth), .AddrW(AddrW)) u_ctrl (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .in_valid_i, .in_item_i, .in_stall_o,
    .out_valid_o, .out_item_o, .out_stall_i,
    .req_we_o(req_we), .req_waddr_o(req_waddr), .req_wdata_o(req_wdata),
    .req_raddr_o(req_raddr), .req_rdata_i(req_rdata),
    .srt_we_o(srt_we), .srt_waddr_o(srt_waddr), .srt_wdata_o(srt_wdata),
    .srt_raddr_o(srt_raddr), .srt_rdata_i(srt_rdata)
  );

endmodule
`default_nettype wire

// File: hdl/dhs_checker.sv
// port-level checks for the disk head scheduler and their bind
`default_nettype none
module dhs_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire dhs_pkg::in_item_t  in_item_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire dhs_pkg::out_item_t out_item_o,
  input wire logic               out_stall_i
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input item changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_end_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.end_visit |-> !out_item_o.last_move)
    else $error("sweep end visit flagged as last move");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result right after reset");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result in the cycle after an accepted item");

endmodule

bind disk_head_scheduler dhs_checker u_dhs_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_item_i, .in_stall_o,
  .out_valid_o, .out_item_o, .out_stall_i
);
`default_nettype wire

// File: dv/disk_head_scheduler_tb.sv
// self-checking testbench for the disk head scheduler: batches, policies and moves
`default_nettype none
module disk_head_scheduler_tb;
  import dhs_pkg::*;

  localparam int Depth = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  in_item_t in_item_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  out_item_t out_item_o;
  logic out_stall_i = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  disk_head_scheduler #(.RequestDepth(Depth)) DUT (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // scheduler mirror state
  policy_e pol_m = POL_FCFS;
  logic [15:0] start_m = '0, prev_m = '0, top_m = TopReset;
  logic [15:0] arrival_q[$];
  logic [15:0] sorted_q[$];
  logic [15:0] head_m;
  logic [20:0] travel_m;

  out_item_t moves_q[$];
  in_item_t pending_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit loading_done = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_move(logic [15:0] dest, logic endv);
    out_item_t m;
    logic [15:0] span;
    span = (head_m > dest) ? head_m - dest : dest - head_m;
    travel_m = travel_m + 21'(span);
    head_m = dest;
    m.destination = dest;
    m.end_visit = endv;
    m.movement_total = travel_m;
    m.last_move = 1'b0;
    moves_q.push_back(m);
  endfunction

  function automatic void schedule_batch();
    int n, up, down, nxt, done, base, i;
    bit upward;
    out_item_t m;
    n = arrival_q.size();
    base = moves_q.size();
    travel_m = '0;
    head_m = start_m;
    upward = prev_m <= start_m;
    if (pol_m == POL_FCFS) begin
      for (i = 0; i < n; i++) push_move(arrival_q[i], 1'b0);
    end else begin
      up = n;
      for (i = 0; i < n; i++) begin
        if (head_m <= sorted_q[i]) begin
          up = i;
          break;
        end
      end
      down = up - 1;
      nxt = upward ? up : down;
      done = 0;
      while (done < n) begin
        if (upward) begin
          if (nxt < n) begin
            push_move(sorted_q[nxt], 1'b0);
            nxt++;
            done++;
          end else if (pol_m == POL_CSCAN) begin
            push_move(top_m, 1'b1);
            push_move('0, 1'b1);
            nxt = 0;
          end else begin
            if (pol_m == POL_SCAN) push_move(top_m, 1'b1);
            upward = 0;
            nxt = down;
          end
        end else begin
          if (nxt >= 0) begin
            push_move(sorted_q[nxt], 1'b0);
            nxt--;
            done++;
          end else if (pol_m == POL_CSCAN) begin
            push_move('0, 1'b1);
            push_move(top_m, 1'b1);
            nxt = n - 1;
          end else begin
            if (pol_m == POL_SCAN) push_move('0, 1'b1);
            upward = 1;
            nxt = up;
          end
        end
      end
    end
    if (moves_q.size() > base) begin
      m = moves_q[$];
      m.last_move = 1'b1;
      moves_q[moves_q.size()-1] = m;
    end
    arrival_q.delete();
    sorted_q.delete();
  endfunction

  function automatic void accept_request(in_item_t it);
    logic [15:0] c;
    int pos;
    if (arrival_q.size() < Depth) begin
      c = (it.cylinder > top_m) ? top_m : it.cylinder;
      arrival_q.push_back(c);
      pos = sorted_q.size();
      while (pos > 0 && sorted_q[pos-1] > c) pos--;
      sorted_q.insert(pos, c);
    end
    if (it.batch_end) schedule_batch();
  endfunction

  logic in_stall_o_q;
  // stall as seen at the last rising edge, which decided acceptance
  always @(posedge clk_i) in_stall_o_q <= in_stall_o;

  // driver
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && in_stall_o_q)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_item_i <= pending_q.pop_front();
          in_valid_i <= 1'b1;
          send_gap <= gap_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  int recv_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        recv_gap <= gap_len();
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t exp_m;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        accept_request(in_item_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (moves_q.size() == 0) begin
          $error("unexpected move destination=%0d", out_item_o.destination);
          errors++;
        end else begin
          exp_m = moves_q.pop_front();
          if (out_item_o.destination !== exp_m.destination) begin
            $error("destination expected %0d actual %0d", exp_m.destination,
                   out_item_o.destination);
            errors++;
          end
          if (out_item_o.end_visit !== exp_m.end_visit) begin
            $error("end_visit expected %0d actual %0d", exp_m.end_visit,
                   out_item_o.end_visit);
            errors++;
          end
          if (out_item_o.movement_total !== exp_m.movement_total) begin
            $error("movement_total expected %0d actual %0d", exp_m.movement_total,
                   out_item_o.movement_total);
            errors++;
          end
          if (out_item_o.last_move !== exp_m.last_move) begin
            $error("last_move expected %0d actual %0d", exp_m.last_move,
                   out_item_o.last_move);
            errors++;
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles > 4000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_POLICY: pol_m = policy_e'(val[1:0]);
      REG_START:  start_m = val[15:0];
      REG_PREV:   prev_m = val[15:0];
      default:    top_m = val[15:0];
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || moves_q.size() > 0) begin
      @(negedge clk_i);
      #1;
    end
    repeat (60) @(negedge clk_i);
  endtask

  task automatic queue_batch(int n, logic [15:0] lim);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.cylinder = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                    : 16'($urandom_range(0, lim));
      it.batch_end = (i == n - 1);
      pending_q.push_back(it);
    end
  endtask

  task automatic random_config();
    logic [15:0] t;
    write_reg(REG_POLICY, $urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: t = 16'hffff;
      1: t = 16'd1;
      default: t = 16'($urandom_range(1, 65535));
    endcase
    write_reg(REG_TOP, t);
    write_reg(REG_START, ($urandom_range(0, 7) == 0) ? 16'($urandom) : $urandom_range(0, t));
    write_reg(REG_PREV, ($urandom_range(0, 5) == 0) ? 16'hffff : 16'($urandom_range(0, t)));
  endtask

  initial begin
    int sent;
    in_item_t it;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: one batch per policy with extremes, zero-length moves, overflow
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_POLICY, p);
      write_reg(REG_START, (p == 3) ? 16'd5000 : 16'd2000);
      write_reg(REG_PREV, (p[0]) ? 16'd3000 : 16'd100);
      it = '{16'hffff, 1'b0}; pending_q.push_back(it);
      it = '{16'd0, 1'b0};    pending_q.push_back(it);
      it = '{16'd2000, 1'b0}; pending_q.push_back(it);
      it = '{16'd4999, 1'b1}; pending_q.push_back(it);
      drain();
    end
    write_reg(REG_TOP, 16'hffff);
    write_reg(REG_START, 16'd10);
    queue_batch(18, 16'hffff);
    it = '{16'h5555, 1'b1}; pending_q.push_back(it);
    drain();
    sent = 0;
    while (sent < 470) begin
      int n;
      random_config();
      for (int b = 0; b < 4; b++) begin
        n = ($urandom_range(0, 9) == 0) ? 17 : $urandom_range(1, 8);
        queue_batch(n, top_m);
        sent += n;
      end
      drain();
    end
    drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
